// ----- rtl/single_half_float_converter_top_defines.svh -----
// ----------------------------------------------------------------------------
// single_half_float_converter_top_defines
// assertion macros used by the converter checker
// ----------------------------------------------------------------------------
`ifndef SINGLE_HALF_FLOAT_CONVERTER_TOP_DEFINES_SVH
`define SINGLE_HALF_FLOAT_CONVERTER_TOP_DEFINES_SVH

// clocked assertion, quiet while reset is held
`define SHFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// stalled beat keeps a signal unchanged
`define SHFC_ASSERT_HOLD(label, vld, rdy, sig, msg) \
    `SHFC_ASSERT(label, (vld && !rdy) |=> $stable(sig), msg)

`endif

// ----- rtl/shfc_pkg.sv -----
// ----------------------------------------------------------------------------
// shfc_pkg
// widths, commands and format constants of the single/half converter
// ----------------------------------------------------------------------------
package shfc_pkg;

    localparam int OPERAND_W = 32;
    localparam int RESULT_W  = 32;
    localparam int HALF_W    = 16;

    typedef logic [OPERAND_W-1:0] operand_t;
    typedef logic [RESULT_W-1:0]  result_t;
    typedef logic [HALF_W-1:0]    half_t;

    localparam logic CMD_NARROW = 1'b0;
    localparam logic CMD_WIDEN  = 1'b1;

    // binary32 fields
    localparam logic [7:0]  SGL_EXP_MAX    = 8'hff;
    localparam logic [22:0] SGL_MAN_MASK   = 23'h7fffff;
    localparam logic [23:0] SGL_HIDDEN_BIT = 24'h800000;
    localparam logic [30:0] SGL_INF_MAG    = 31'h7f800000;

    // binary16 fields
    localparam logic [14:0] HALF_INF_MAG   = 15'h7c00;
    localparam logic [14:0] HALF_QNAN_BIT  = 15'h0200;
    localparam logic [4:0]  HALF_EXP_MAX   = 5'd31;
    localparam logic [9:0]  HALF_MAN_MASK  = 10'h3ff;

    // exponent rebias and range limits
    localparam logic [7:0]  EXP_REBIAS     = 8'd112;
    localparam logic [7:0]  SGL_EXP_OVF    = 8'd143;
    localparam logic [7:0]  SGL_EXP_SUB_LO = 8'd102;
    localparam logic [7:0]  SGL_EXP_SUB_HI = 8'd112;
    localparam logic [7:0]  SGL_EXP_SUB_SH = 8'd113;
    localparam logic [4:0]  HALF_EXP_TOP   = 5'd30;
    localparam logic [7:0]  SGL_EXP_NORM0  = 8'd103;

    // half ulp at the narrowing truncation point
    localparam logic [23:0] ROUND_HALF     = 24'h001000;
    localparam int          MAN_DROP       = 13;

endpackage

// ----- rtl/shfc_in_if.sv -----
// ----------------------------------------------------------------------------
// shfc_in_if
// operand channel: valid/ready with command and operand bits
// ----------------------------------------------------------------------------
interface shfc_in_if
    import shfc_pkg::*;
();
    logic     valid;
    logic     ready;
    logic     command;
    operand_t operand_bits;

    modport source (output valid, output command, output operand_bits, input ready);
    modport sink   (input valid, input command, input operand_bits, output ready);
endinterface

// ----- rtl/shfc_out_if.sv -----
// ----------------------------------------------------------------------------
// shfc_out_if
// result channel: valid/ready with result bits
// ----------------------------------------------------------------------------
interface shfc_out_if
    import shfc_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t result_bits;

    modport source (output valid, output result_bits, input ready);
    modport sink   (input valid, input result_bits, output ready);
endinterface

// ----- rtl/shfc_narrow.sv -----
// ----------------------------------------------------------------------------
// shfc_narrow
// binary32 to binary16, half ulp added, ties away from zero
// ----------------------------------------------------------------------------
module shfc_narrow
    import shfc_pkg::*;
(
    input  operand_t operand_bits,
    output half_t    half_bits
);

    logic        sign;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [3:0]  sub_shift;
    logic [23:0] sub_man;
    logic [23:0] sub_rnd;
    logic [23:0] nrm_rnd;
    logic [4:0]  nrm_exp;
    logic        nrm_carry;

    assign sign      = operand_bits[31];
    assign ex        = operand_bits[30:23];
    assign man       = operand_bits[22:0] & SGL_MAN_MASK;
    assign sub_shift = 4'(SGL_EXP_SUB_SH - ex);
    assign sub_man   = (SGL_HIDDEN_BIT | {1'b0, man}) >> sub_shift;
    assign sub_rnd   = sub_man + ROUND_HALF;
    assign nrm_rnd   = {1'b0, man} + ROUND_HALF;
    assign nrm_carry = nrm_rnd[23];
    assign nrm_exp   = 5'(ex - EXP_REBIAS);

    always_comb
    begin
        if (ex == SGL_EXP_MAX)
        begin
            half_bits = {sign, HALF_INF_MAG | ((man != '0) ? HALF_QNAN_BIT : '0)};
        end
        else if (ex >= SGL_EXP_OVF)
        begin
            half_bits = {sign, HALF_INF_MAG};
        end
        else if (ex < SGL_EXP_SUB_LO)
        begin
            half_bits = {sign, 15'd0};
        end
        else if (ex <= SGL_EXP_SUB_HI)
        begin
            half_bits = {sign, 4'd0, sub_rnd[MAN_DROP+10:MAN_DROP]};
        end
        else if (nrm_carry && nrm_exp == HALF_EXP_TOP)
        begin
            half_bits = {sign, HALF_INF_MAG};
        end
        else if (nrm_carry)
        begin
            half_bits = {sign, nrm_exp + 5'd1, 10'd0};
        end
        else
        begin
            half_bits = {sign, nrm_exp, nrm_rnd[MAN_DROP+9:MAN_DROP]};
        end
    end

endmodule

// ----- rtl/shfc_widen.sv -----
// ----------------------------------------------------------------------------
// shfc_widen
// binary16 to binary32, exact, subnormals normalized
// ----------------------------------------------------------------------------
module shfc_widen
    import shfc_pkg::*;
(
    input  half_t   half_bits,
    output result_t result_bits
);

    logic       sign;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] lead;
    logic [3:0] norm_shift;
    logic [9:0] norm_man;
    logic [7:0] norm_exp;

    assign sign = half_bits[15];
    assign ex   = half_bits[14:10];
    assign man  = half_bits[9:0] & HALF_MAN_MASK;

    // position of the leading one in a subnormal mantissa
    always_comb
    begin
        lead = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (man[i])
            begin
                lead = 4'(i);
            end
        end
    end

    assign norm_shift = 4'd10 - lead;
    assign norm_man   = 10'({1'b0, man} << norm_shift);
    assign norm_exp   = SGL_EXP_NORM0 + {4'd0, lead};

    always_comb
    begin
        if (ex == 5'd0)
        begin
            if (man == '0)
            begin
                result_bits = {sign, 31'd0};
            end
            else
            begin
                result_bits = {sign, norm_exp, norm_man, 13'd0};
            end
        end
        else if (ex == HALF_EXP_MAX)
        begin
            result_bits = {sign, SGL_INF_MAG | {8'd0, man, 13'd0}};
        end
        else
        begin
            result_bits = {sign, {3'd0, ex} + EXP_REBIAS, man, 13'd0};
        end
    end

endmodule

// ----- rtl/single_half_float_converter_top.sv -----
// ----------------------------------------------------------------------------
// single_half_float_converter_top
// registered binary32/binary16 converter, unless stalled one beat per cycle
// ----------------------------------------------------------------------------
//  channel  | dir | fields                  | handshake
//  in_ch    | in  | command, operand_bits   | valid/ready
//  out_ch   | out | result_bits             | valid/ready
//
//  one beat accepted per cycle unless held by a stalled result
//  path: input register, narrow/widen logic, result register
//  reset clears both valid flags, payload registers are not reset
//  a stalled result holds the pipe, a full s1 then drops input ready
// ----------------------------------------------------------------------------
module single_half_float_converter_top
    import shfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    shfc_in_if.sink    in_ch,
    shfc_out_if.source out_ch
);

    logic     s1_valid_reg;
    logic     s1_valid_next;
    logic     s1_cmd_reg;
    operand_t s1_op_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    result_t  out_result_reg;
    result_t  out_result_next;
    logic     out_load;
    logic     in_load;
    half_t    narrow_bits;
    result_t  widen_bits;

    assign out_load = !out_valid_reg || out_ch.ready;
    assign in_load  = !s1_valid_reg || out_load;

    assign in_ch.ready = in_load;

    shfc_narrow u_narrow
    (
        .operand_bits (s1_op_reg),
        .half_bits    (narrow_bits)
    );

    shfc_widen u_widen
    (
        .half_bits   (s1_op_reg[HALF_W-1:0]),
        .result_bits (widen_bits)
    );

    always_comb
    begin
        case (s1_cmd_reg)
            CMD_NARROW: out_result_next = {16'd0, narrow_bits};
            CMD_WIDEN:  out_result_next = widen_bits;
            default:    out_result_next = widen_bits;
        endcase
    end

    always_comb
    begin
        s1_valid_next  = in_load ? in_ch.valid : s1_valid_reg;
        out_valid_next = out_load ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && in_ch.valid)
        begin
            s1_cmd_reg <= in_ch.command;
            s1_op_reg  <= in_ch.operand_bits;
        end
        if (out_load && s1_valid_reg)
        begin
            out_result_reg <= out_result_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.result_bits = out_result_reg;

endmodule

// ----- rtl/shfc_chk.sv -----
// ----------------------------------------------------------------------------
// shfc_chk
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`include "single_half_float_converter_top_defines.svh"

module shfc_chk
    import shfc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t result_bits
);

    // stalled result beat stays offered
    `SHFC_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "result beat dropped")

    `SHFC_ASSERT_HOLD(a_out_stable, out_valid, out_ready, result_bits, "stalled result changed")

    // an accepted beat with the sink ready passes s1 to the result register
    `SHFC_ASSERT(a_latency, (in_valid && in_ready) ##1 out_ready |=> out_valid, "result late")

    // a free result side never stalls the operand side
    `SHFC_ASSERT(a_no_backpressure, (out_ready || !out_valid) |-> in_ready, "input stalled")

endmodule

bind single_half_float_converter_top shfc_chk u_shfc_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .result_bits (out_ch.result_bits)
);
